// ===== rtl/core/bfba_pkg.sv =====
// ============================================================================
// Best-fit block allocator package
// Shared sizes, field types, item codes and controller types.
// ============================================================================
`timescale 1ns / 1ps

package bfba_pkg;

    localparam int MAX_BLOCKS        = 16;
    localparam int SIZE_BITS         = 16;
    localparam int BLOCK_INDEX_W     = 4;
    localparam int BLOCK_COUNT_W     = 5;
    localparam int BLOCK_COUNT_RESET = 16;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int LIM_W = $clog2(MAX_BLOCKS + 1);

    typedef logic [SIZE_BITS-1:0]     size_t;
    typedef logic [BLOCK_INDEX_W-1:0] block_index_t;
    typedef logic [BLOCK_COUNT_W-1:0] block_count_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [LIM_W-1:0]         lim_t;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        size_t wr_data;
    } ram_cmd_t;

    typedef struct packed {
        logic         allocated;
        block_index_t chosen_block;
        size_t        size_left;
    } result_t;

endpackage

// ===== rtl/core/bfba_if.sv =====
// ============================================================================
// Best-fit block allocator channels
// Valid/ready channels for request items, result items and configuration.
// ============================================================================
`timescale 1ns / 1ps

interface bfba_req_if;
    import bfba_pkg::*;

    logic         valid;
    logic         ready;
    logic         kind;
    block_index_t block_index;
    size_t        amount;

    modport source (output valid, output kind, output block_index, output amount,
                    input ready);
    modport sink   (input valid, input kind, input block_index, input amount,
                    output ready);
endinterface

interface bfba_rsp_if;
    import bfba_pkg::*;

    logic         valid;
    logic         ready;
    logic         allocated;
    block_index_t chosen_block;
    size_t        size_left;

    modport source (output valid, output allocated, output chosen_block,
                    output size_left, input ready);
    modport sink   (input valid, input allocated, input chosen_block,
                    input size_left, output ready);
endinterface

interface bfba_cfg_if;
    import bfba_pkg::*;

    logic         valid;
    logic         ready;
    block_count_t block_count;

    modport source (output valid, output block_count, input ready);
    modport sink   (input valid, input block_count, output ready);
endinterface

// ===== rtl/core/bfba_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
`timescale 1ns / 1ps

module bfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bfba_ctrl.sv =====
// ============================================================================
// Best-fit allocator controller
// Takes load and request items, scans the size table one entry per cycle
// and writes back the reduced size of the chosen block.
// ============================================================================
`timescale 1ns / 1ps

module bfba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    bfba_req_if.sink            req,
    input  bfba_pkg::lim_t      limit,
    input  bfba_pkg::size_t     rd_data,
    input  logic                res_ready,
    output bfba_pkg::ram_cmd_t  ram_cmd,
    output logic                res_valid,
    output bfba_pkg::result_t   res
);
    import bfba_pkg::*;

    ctrl_state_t state_reg, state_next;
    lim_t        issue_cnt_reg, issue_cnt_next;
    logic        rd_valid_reg, rd_valid_next;
    idx_t        rd_idx_reg, rd_idx_next;
    size_t       amount_reg, amount_next;
    logic        found_reg, found_next;
    idx_t        best_idx_reg, best_idx_next;
    size_t       best_size_reg, best_size_next;

    logic accept_alloc;
    logic accept_load;
    logic load_in_range;
    logic better;

    assign accept_alloc  = req.valid && req.ready && (req.kind == KIND_ALLOC);
    assign accept_load   = req.valid && req.ready && (req.kind == KIND_LOAD);
    assign load_in_range = int'(req.block_index) < MAX_BLOCKS;
    assign better        = (rd_data >= amount_reg) &&
                           (!found_reg || (rd_data < best_size_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_alloc)
                begin
                    state_next = (limit == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((issue_cnt_reg + LIM_W'(1)) == limit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready         = 1'b0;
        res_valid         = 1'b0;
        ram_cmd.rd_en     = 1'b0;
        ram_cmd.rd_addr   = issue_cnt_reg[IDX_W-1:0];
        ram_cmd.wr_en     = 1'b0;
        ram_cmd.wr_addr   = IDX_W'(req.block_index);
        ram_cmd.wr_data   = req.amount;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready     = 1'b1;
                ram_cmd.wr_en = accept_load && load_in_range;
            end
            ST_SCAN:
            begin
                ram_cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                ram_cmd.rd_en = 1'b0;
            end
            ST_DONE:
            begin
                res_valid       = 1'b1;
                ram_cmd.wr_en   = res_ready && found_reg;
                ram_cmd.wr_addr = best_idx_reg;
                ram_cmd.wr_data = best_size_reg - amount_reg;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.allocated    = found_reg;
        res.chosen_block = found_reg ? BLOCK_INDEX_W'(best_idx_reg) : '0;
        res.size_left    = found_reg ? (best_size_reg - amount_reg) : '0;
    end

    always_comb
    begin
        issue_cnt_next = issue_cnt_reg;
        rd_valid_next  = (state_reg == ST_SCAN);
        rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
        amount_next    = amount_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        if (accept_alloc)
        begin
            issue_cnt_next = '0;
            amount_next    = req.amount;
            found_next     = 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            issue_cnt_next = issue_cnt_reg + LIM_W'(1);
        end
        if (rd_valid_reg && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_size_next = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        amount_reg    <= amount_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
    end

endmodule

// ===== rtl/core/best_fit_block_allocator.sv =====
// ============================================================================
// Best-fit block allocator
// Table of free block sizes with best-fit allocation requests.
// ============================================================================
// Usage:
// Items arrive on req. A load item (kind 0) writes amount into the table entry
// block_index in the cycle it is accepted and gives no result. A request item
// (kind 1) scans the first block_count entries for the smallest free size that
// holds amount, lowest index on a tie, subtracts amount from it and returns
// one item on rsp: allocated, chosen_block and size_left.
// The cfg channel writes block_count; it is always ready, and the user must
// write it only while no request is in flight; the block does not enforce this.
// A request reads one table entry per cycle from a single-port-read RAM, passing
// through the states SCAN, DRAIN and DONE before its result reaches rsp (block_count
// capped at 16; with block_count zero it goes straight to DONE); req is ready again
// in the cycle the result reaches rsp. The result sits in an output register;
// while rsp is stalled the block still accepts a new item, and a second request
// finishes its scan and waits until the register is taken.
// Reset clears the control state and sets block_count to 16; table entries
// are undefined until loaded.
// ============================================================================
`timescale 1ns / 1ps

module best_fit_block_allocator (
    input  logic       clk,
    input  logic       rst_n,
    bfba_req_if.sink   req,
    bfba_rsp_if.source rsp,
    bfba_cfg_if.sink   cfg
);
    import bfba_pkg::*;

    block_count_t block_count_reg, block_count_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;

    lim_t     limit;
    size_t    rd_data;
    ram_cmd_t ram_cmd;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    assign limit = (int'(block_count_reg) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                                        : LIM_W'(block_count_reg);

    assign cfg.ready = 1'b1;
    assign res_ready = !out_valid_reg || rsp.ready;

    bfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .limit     (limit),
        .rd_data   (rd_data),
        .res_ready (res_ready),
        .ram_cmd   (ram_cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    bfba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_cmd.wr_en),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (ram_cmd.wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        block_count_next = block_count_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        if (cfg.valid && cfg.ready)
        begin
            block_count_next = cfg.block_count;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_W'(BLOCK_COUNT_RESET);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            block_count_reg <= block_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.allocated    = out_reg.allocated;
    assign rsp.chosen_block = out_reg.chosen_block;
    assign rsp.size_left    = out_reg.size_left;

`ifndef SYNTHESIS
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_cmd.rd_en && ram_cmd.wr_en))
        else $error("Table read and write in the same cycle.");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.kind == KIND_ALLOC)) |=> !req.ready)
        else $error("Request accepted while a scan should be running.");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.allocated) |->
            ((rsp.chosen_block == '0) && (rsp.size_left == '0)))
        else $error("Unallocated result carries nonzero fields.");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.allocated) |->
            (int'(rsp.chosen_block) < int'(limit)))
        else $error("Chosen block lies beyond the searched range.");
`endif

endmodule

// ===== tb/sv/best_fit_block_allocator_tb.sv =====
// ============================================================================
// Best-fit block allocator testbench
// Loads every table entry, then sends load and request items under several
// block counts and three idle patterns. Expected results are worked out by a
// scoreboard that keeps its own copy of the free size table and is checked
// field by field against each result taken from the block.
// ============================================================================
`timescale 1ns / 1ps

module best_fit_block_allocator_tb;
    import bfba_pkg::*;

    class alloc_checker;
        size_t        free_size [MAX_BLOCKS];
        block_count_t count;
        result_t      pending_grants [$];
        int           errors;
        int           loads;
        int           requests;
        int           grants;
        int           refusals;

        function new();
            foreach (free_size[i])
            begin
                free_size[i] = '0;
            end
            count    = block_count_t'(BLOCK_COUNT_RESET);
            errors   = 0;
            loads    = 0;
            requests = 0;
            grants   = 0;
            refusals = 0;
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            if (errors < 30)
            begin
                $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
            end
            errors++;
        endtask

        function void note_item(input logic kind, input block_index_t idx, input size_t amount);
            result_t grant;
            int      lim;
            int      best;
            bit      found;
            grant = '0;
            best  = 0;
            found = 1'b0;
            if (kind == KIND_LOAD)
            begin
                free_size[idx] = amount;
                loads++;
            end
            else
            begin
                lim = (int'(count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(count);
                for (int j = 0; j < lim; j++)
                begin
                    if (free_size[j] >= amount && (!found || free_size[j] < free_size[best]))
                    begin
                        best  = j;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    free_size[best]    = free_size[best] - amount;
                    grant.allocated    = 1'b1;
                    grant.chosen_block = block_index_t'(best);
                    grant.size_left    = free_size[best];
                    grants++;
                end
                else
                begin
                    refusals++;
                end
                requests++;
                pending_grants.push_back(grant);
            end
        endfunction

        task check_result(input logic allocated, input block_index_t chosen, input size_t left);
            result_t want;
            if (pending_grants.size() == 0)
            begin
                report_mismatch("result with no request waiting, allocated", allocated, 0);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (allocated !== want.allocated)
                begin
                    report_mismatch("allocated", allocated, want.allocated);
                end
                if (chosen !== want.chosen_block)
                begin
                    report_mismatch("chosen_block", chosen, want.chosen_block);
                end
                if (left !== want.size_left)
                begin
                    report_mismatch("size_left", left, want.size_left);
                end
            end
        endtask
    endclass

    localparam int SETTLE_CYCLES = MAX_BLOCKS + 8;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 180;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   settings_used;

    alloc_checker sb = new();

    bfba_req_if req_ch ();
    bfba_rsp_if rsp_ch ();
    bfba_cfg_if cfg_ch ();

    best_fit_block_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic send_item(input logic kind, input block_index_t idx, input size_t amt);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.kind        = kind;
        req_ch.block_index = idx;
        req_ch.amount      = amt;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(kind, idx, amt);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_block_count(input block_count_t value);
        wait_idle();
        cfg_ch.valid       = 1'b1;
        cfg_ch.block_count = value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        sb.count = value;
        settings_used++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_random_item();
        int           lim;
        int           pick;
        block_index_t idx;
        size_t        amt;
        size_t        entry;
        lim = (int'(sb.count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(sb.count);
        if (lim == 0)
        begin
            lim = MAX_BLOCKS;
        end
        idx   = block_index_t'($urandom_range(0, MAX_BLOCKS - 1));
        entry = sb.free_size[$urandom_range(0, lim - 1)];
        pick  = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 30)
        begin
            if (pick < 35)
                amt = size_t'($urandom);
            else if (pick < 55)
                amt = size_t'($urandom_range(0, 64));
            else if (pick < 75)
                amt = sb.free_size[$urandom_range(0, MAX_BLOCKS - 1)];
            else if (pick < 85)
                amt = '1;
            else if (pick < 90)
                amt = '0;
            else
                amt = size_t'($urandom_range(1000, 5000));
            send_item(KIND_LOAD, idx, amt);
        end
        else
        begin
            if (pick < 5)
                amt = '0;
            else if (pick < 35)
                amt = entry;
            else if (pick < 45)
                amt = entry + 1'b1;
            else if (pick < 75)
                amt = size_t'($urandom_range(1, 256));
            else if (pick < 90)
                amt = size_t'($urandom);
            else
                amt = '1;
            send_item(KIND_ALLOC, idx, amt);
        end
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
            begin
                sb.check_result(rsp_ch.allocated, rsp_ch.chosen_block, rsp_ch.size_left);
            end
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        size_t        init_sizes [MAX_BLOCKS];
        size_t        first_asks [5];
        block_count_t phase_counts [PHASES];
        init_sizes   = '{16'hFFFF, 16'h0000, 16'd100, 16'd100, 16'h5555, 16'hAAAA, 16'd500,
                         16'd50, 16'd1000, 16'd20000, 16'd300, 16'd100, 16'd7, 16'd60000,
                         16'h8000, 16'h7FFF};
        first_asks   = '{16'd0, 16'd100, 16'hFFFF, 16'd60001, 16'd99};
        phase_counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd9, 5'd2, 5'd17, 5'd15, 5'd6};

        rst_n              = 1'b0;
        src_idle_pct       = 23;
        sink_idle_pct      = 55;
        settings_used      = 0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_LOAD;
        req_ch.block_index = '0;
        req_ch.amount      = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.block_count = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every entry is loaded before any request can scan it.
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            send_item(KIND_LOAD, block_index_t'(i), init_sizes[i]);
        end
        foreach (first_asks[i])
        begin
            send_item(KIND_ALLOC, block_index_t'(i), first_asks[i]);
        end
        write_block_count(5'd0);
        send_item(KIND_ALLOC, '0, '0);
        write_block_count(5'd31);
        send_item(KIND_ALLOC, '1, 16'd1);
        write_block_count(5'd1);
        send_item(KIND_ALLOC, '0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct  = (p < 3) ? 23 : ((p < 6) ? 55 : 0);
            sink_idle_pct = (p < 3) ? 55 : ((p < 6) ? 23 : 0);
            write_block_count(phase_counts[p]);
            repeat (PHASE_ITEMS) send_random_item();
        end

        wait_idle();
        $display("summary: %0d loads, %0d requests (%0d allocated, %0d refused)",
                 sb.loads, sb.requests, sb.grants, sb.refusals);
        $display("summary: %0d block count settings, three idle patterns, %0d mismatches",
                 settings_used, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
